// ----- hdl/tesf_pkg.sv -----
// Shared types, constants and command/status structs of the escape sequence filter.
package tesf_pkg;

   localparam int PARAM_DEPTH_DEFAULT = 16;

   localparam logic [7:0] ESC_BYTE      = 8'h1B;
   localparam logic [7:0] LBRACKET_BYTE = 8'h5B;
   localparam logic [7:0] FINAL_LO      = 8'h40;
   localparam logic [7:0] FINAL_HI      = 8'h7E;
   localparam logic [6:0] SAFE_RESET    = 7'h6D;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_CSI  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      SEL_CUR   = 3'd0,
      SEL_BYTE  = 3'd1,
      SEL_ESC   = 3'd2,
      SEL_LB    = 3'd3,
      SEL_PARAM = 3'd4,
      SEL_ZERO  = 3'd5
   } out_sel_type;

   typedef struct packed {
      logic        use_held;
      logic        latch_byte;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
      logic        mode_we;
      mode_type    mode_next;
      logic        clear_seq;
      logic        store_param;
      logic        set_overlong;
      logic        flush_start;
      logic        flush_adv;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     cur_is_esc;
      logic     cur_is_lb;
      logic     cur_is_zero;
      logic     cur_is_final;
      logic     cur_is_safe;
      logic     count_full;
      logic     overlong;
      logic     params_empty;
      logic     flush_last;
      logic     out_free;
   } status_type;

endpackage

// ----- hdl/tesf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tesf_ctrl.sv -----
// Controller state machine: decodes each request and sequences multi-byte output.
module tesf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tesf_pkg::status_type status,
   output tesf_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_HOLD = 6'b000010,
      S_EMIT = 6'b000100,
      S_FLB  = 6'b001000,
      S_FPAR = 6'b010000,
      S_FFIN = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.out_sel   = tesf_pkg::SEL_CUR;
      cmd.mode_next = tesf_pkg::MODE_TEXT;
      cmd.use_held  = (state_ff == S_HOLD);
      state_in      = state_ff;
      go            = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_byte = 1'b1;
               if (status.out_free) begin
                  go = 1'b1;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            go = status.out_free;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tesf_pkg::SEL_BYTE;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FLB: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tesf_pkg::SEL_LB;
               state_in     = status.params_empty ? S_FFIN : S_FPAR;
            end
         end
         S_FPAR: begin
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_sel   = tesf_pkg::SEL_PARAM;
               cmd.flush_adv = 1'b1;
               if (status.flush_last) begin
                  state_in = S_FFIN;
               end
            end
         end
         S_FFIN: begin
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_sel   = tesf_pkg::SEL_BYTE;
               cmd.out_last  = 1'b1;
               cmd.clear_seq = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Decode the current byte against the scan mode.
      if (go) begin
         state_in = S_IDLE;
         case (status.mode)
            tesf_pkg::MODE_ESC: begin
               if (status.cur_is_lb) begin
                  cmd.mode_we   = 1'b1;
                  cmd.mode_next = tesf_pkg::MODE_CSI;
                  cmd.clear_seq = 1'b1;
               end else if (status.cur_is_esc) begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = tesf_pkg::SEL_ESC;
                  cmd.out_last = 1'b1;
               end else begin
                  cmd.load_out  = 1'b1;
                  cmd.out_sel   = tesf_pkg::SEL_ESC;
                  cmd.mode_we   = 1'b1;
                  cmd.mode_next = tesf_pkg::MODE_TEXT;
                  state_in      = S_EMIT;
               end
            end
            tesf_pkg::MODE_CSI: begin
               if (status.cur_is_zero) begin
                  cmd.load_out  = 1'b1;
                  cmd.out_sel   = tesf_pkg::SEL_ZERO;
                  cmd.out_last  = 1'b1;
                  cmd.clear_seq = 1'b1;
                  cmd.mode_we   = 1'b1;
                  cmd.mode_next = tesf_pkg::MODE_TEXT;
               end else if (status.cur_is_final) begin
                  cmd.mode_we   = 1'b1;
                  cmd.mode_next = tesf_pkg::MODE_TEXT;
                  if (status.cur_is_safe && !status.overlong) begin
                     cmd.load_out    = 1'b1;
                     cmd.out_sel     = tesf_pkg::SEL_ESC;
                     cmd.flush_start = 1'b1;
                     state_in        = S_FLB;
                  end else begin
                     cmd.clear_seq = 1'b1;
                  end
               end else if (!status.count_full) begin
                  cmd.store_param = 1'b1;
               end else begin
                  cmd.set_overlong = 1'b1;
               end
            end
            default: begin
               if (status.cur_is_esc) begin
                  cmd.mode_we   = 1'b1;
                  cmd.mode_next = tesf_pkg::MODE_ESC;
               end else begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = tesf_pkg::SEL_CUR;
                  cmd.out_last = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

// ----- hdl/tesf_dp.sv -----
// Datapath: scan mode, parameter buffer, safe byte register and output register.
module tesf_dp #(
   parameter int PARAM_DEPTH = tesf_pkg::PARAM_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_byte,
   input  logic                 csr_we,
   input  logic [6:0]           csr_value,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   input  tesf_pkg::cmd_type    cmd,
   output tesf_pkg::status_type status
);

   localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
   localparam int CW = $clog2(PARAM_DEPTH + 1);

   logic [7:0]         byte_ff, byte_in;
   logic [7:0]         cur_byte;
   logic [6:0]         safe_ff;
   tesf_pkg::mode_type mode_ff;
   logic [CW-1:0]      count_ff;
   logic               overlong_ff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [7:0]         param_rd;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff;
   logic               out_free;

   assign cur_byte = cmd.use_held ? byte_ff : req_byte;
   assign byte_in  = cmd.latch_byte ? req_byte : byte_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.flush_start) begin
         idx_in = '0;
      end else if (cmd.flush_adv) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      case (cmd.out_sel)
         tesf_pkg::SEL_CUR:   out_byte_in = cur_byte;
         tesf_pkg::SEL_BYTE:  out_byte_in = byte_ff;
         tesf_pkg::SEL_ESC:   out_byte_in = tesf_pkg::ESC_BYTE;
         tesf_pkg::SEL_LB:    out_byte_in = tesf_pkg::LBRACKET_BYTE;
         tesf_pkg::SEL_PARAM: out_byte_in = param_rd;
         tesf_pkg::SEL_ZERO:  out_byte_in = 8'h00;
         default:             out_byte_in = cur_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      idx_ff  <= idx_in;
      if (cmd.load_out) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_ff      <= tesf_pkg::SAFE_RESET;
         mode_ff      <= tesf_pkg::MODE_TEXT;
         count_ff     <= '0;
         overlong_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            safe_ff <= csr_value;
         end
         if (cmd.mode_we) begin
            mode_ff <= cmd.mode_next;
         end
         if (cmd.clear_seq) begin
            count_ff    <= '0;
            overlong_ff <= 1'b0;
         end else begin
            if (cmd.store_param) begin
               count_ff <= count_ff + CW'(1);
            end
            if (cmd.set_overlong) begin
               overlong_ff <= 1'b1;
            end
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   tesf_ram #(
      .WIDTH (8),
      .DEPTH (PARAM_DEPTH)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (cmd.store_param),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cur_byte),
      .rd_addr (idx_in),
      .rd_data (param_rd)
   );

   assign status.mode         = mode_ff;
   assign status.cur_is_esc   = (cur_byte == tesf_pkg::ESC_BYTE);
   assign status.cur_is_lb    = (cur_byte == tesf_pkg::LBRACKET_BYTE);
   assign status.cur_is_zero  = (cur_byte == 8'h00);
   assign status.cur_is_final = (cur_byte >= tesf_pkg::FINAL_LO) &&
                                (cur_byte <= tesf_pkg::FINAL_HI);
   assign status.cur_is_safe  = (cur_byte == {1'b0, safe_ff});
   assign status.count_full   = (count_ff == CW'(PARAM_DEPTH));
   assign status.overlong     = overlong_ff;
   assign status.params_empty = (count_ff == '0);
   assign status.flush_last   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign status.out_free     = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hdl/terminal_escape_sequence_filter_core.sv -----
// Top level of the terminal escape sequence filter: controller, datapath and checks.
//
// Usage:
//   req_* carries one text byte per request; a zero byte ends the line.
//   rsp_* carries the filtered bytes; rsp_tlast marks the last response byte
//   caused by one request. csr_* writes the safe final byte (7 bits); it is
//   always ready and must only be written while the filter is idle.
// Output sequencing and throughput:
//   A plain byte is loaded into the output register that drives rsp_tdata, and
//   plain text flows at one byte per cycle while rsp_tready stays high. ESC
//   then a byte other than '[' or ESC yields two response bytes, ESC and then
//   that byte, with req_tready low while the second is emitted. A passed
//   control sequence with N buffered parameter bytes is replayed from the
//   parameter RAM as N+3 bytes, req_tready low from the '[' to the final byte.
//   ESC, '[', parameter bytes and dropped sequences produce no response.
// Reset:
//   Return to plain text mode, empty the parameter buffer and restore the
//   safe final byte to 'm'. The parameter RAM itself is not cleared.
// Backpressure:
//   The output register holds its byte while rsp_tready is low; one more
//   request is taken and held, then req_tready drops until space frees up.
module terminal_escape_sequence_filter_core #(
   parameter int PARAM_DEPTH = tesf_pkg::PARAM_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request: [7:0] in_byte
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   // response: [7:0] out_byte; tlast carries last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   // config write: [6:0] safe_final_byte, [7] zero
   input  logic       csr_tvalid,
   output logic       csr_tready,
   input  logic [7:0] csr_tdata
);

   tesf_pkg::cmd_type    cmd;
   tesf_pkg::status_type status;

   // Config register accepts a write in any cycle.
   assign csr_tready = 1'b1;

   tesf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tesf_dp #(
      .PARAM_DEPTH (PARAM_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .csr_we     (csr_tvalid && csr_tready),
      .csr_value  (csr_tdata[6:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef SYNTH
   // Never overwrite a response that has not been taken.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("response loaded while output register busy");

   // Buffer a parameter byte only while there is room.
   a_store_room: assert property (@(posedge clock) disable iff (reset)
      cmd.store_param |-> !status.count_full)
      else $error("parameter stored into full buffer");

   // An overlong sequence only arises after the buffer filled.
   a_overlong_full: assert property (@(posedge clock) disable iff (reset)
      status.overlong |-> status.count_full)
      else $error("overlong flag set with buffer not full");

   // No request is taken while a sequence is being replayed.
   a_no_accept_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_adv |-> !req_tready)
      else $error("request ready during sequence replay");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench of the escape sequence filter: table-driven directed bytes, then random text and sequences.
module tb_top;

   localparam int PARAM_DEPTH = tesf_pkg::PARAM_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 30;      // longest replay is PARAM_DEPTH + 3 bytes
   localparam int PHASE_ITEMS = 40;
   localparam logic [7:0] LINE_END = 8'h00;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_item_type;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      ROW_PREDICTED = 2'd0,
      ROW_SILENT    = 2'd1,
      ROW_SINGLE    = 2'd2
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   data;
      row_kind_type kind;
      logic [7:0]   typed;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;
   logic       csr_tvalid = 1'b0;
   logic       csr_tready;
   logic [7:0] csr_tdata = 8'h00;   // [6:0] safe_final_byte, [7] zero

   // filter state as the bench sees it
   tesf_pkg::mode_type pred_mode;
   logic [7:0]         pred_params [PARAM_DEPTH];
   int                 pred_count;
   logic               pred_overlong;
   logic [6:0]         pred_safe;

   rsp_item_type step_out[$];       // bytes caused by the current request
   rsp_item_type expected_out[$];   // bytes still owed by the filter
   rsp_item_type head_item;

   int  err_count = 0;
   int  req_count = 0;
   int  rsp_count = 0;
   int  cycle_count = 0;
   int  max_params = 0;
   int  stall_left = 0;
   bit  send_burst = 1'b0;
   bit  rsp_burst = 1'b0;

   // Directed bytes, starting from reset with 'm' as the safe final byte.
   dir_row_type dir_rows [24] = '{
      '{LINE_END,                ROW_SINGLE,    LINE_END},   // bare terminator
      '{8'hFF,                   ROW_SINGLE,    8'hFF},      // top of the byte range
      '{8'h41,                   ROW_SINGLE,    8'h41},
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},      // ESC held back
      '{LINE_END,                ROW_PREDICTED, 8'h00},      // ESC then terminator
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},
      '{tesf_pkg::ESC_BYTE,      ROW_SINGLE,    tesf_pkg::ESC_BYTE},
      '{8'h78,                   ROW_PREDICTED, 8'h00},      // ESC then ordinary byte
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},
      '{tesf_pkg::LBRACKET_BYTE, ROW_SILENT,    8'h00},
      '{8'h31,                   ROW_SILENT,    8'h00},
      '{8'h3B,                   ROW_SILENT,    8'h00},
      '{8'hFF,                   ROW_SILENT,    8'h00},
      '{8'h6D,                   ROW_PREDICTED, 8'h00},      // safe final: replay sequence
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},
      '{tesf_pkg::LBRACKET_BYTE, ROW_SILENT,    8'h00},
      '{8'h48,                   ROW_SILENT,    8'h00},      // unsafe final: drop
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},
      '{tesf_pkg::LBRACKET_BYTE, ROW_SILENT,    8'h00},
      '{8'h32,                   ROW_SILENT,    8'h00},
      '{LINE_END,                ROW_SINGLE,    LINE_END},   // line ends inside the sequence
      '{tesf_pkg::ESC_BYTE,      ROW_SILENT,    8'h00},
      '{tesf_pkg::LBRACKET_BYTE, ROW_SILENT,    8'h00},
      '{tesf_pkg::FINAL_LO,      ROW_SILENT,    8'h00}       // lowest final, no parameters
   };

   logic [6:0] safe_settings [6] = '{7'h7E, 7'h40, 7'h00, 7'h7F, 7'h6D, 7'h6D};

   terminal_escape_sequence_filter_core #(.PARAM_DEPTH(PARAM_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #6 clock = ~clock;

   function void put_out(input logic [7:0] b);
      step_out.push_back('{out_byte: b, last: 1'b0});
   endfunction

   function void drop_sequence();
      pred_count = 0;
      pred_overlong = 1'b0;
   endfunction

   // Advance the filter state by one request and collect the bytes it releases.
   function void filter_byte(input logic [7:0] b);
      step_out.delete();
      if (pred_mode == tesf_pkg::MODE_CSI) begin
         if (b == LINE_END) begin
            drop_sequence();
            pred_mode = tesf_pkg::MODE_TEXT;
            put_out(LINE_END);
         end else if (b >= tesf_pkg::FINAL_LO && b <= tesf_pkg::FINAL_HI) begin
            // an out-of-range safe byte never equals a final byte
            if (!pred_overlong && b == {1'b0, pred_safe}) begin
               put_out(tesf_pkg::ESC_BYTE);
               put_out(tesf_pkg::LBRACKET_BYTE);
               for (int i = 0; i < pred_count; i++) put_out(pred_params[i]);
               put_out(b);
            end
            drop_sequence();
            pred_mode = tesf_pkg::MODE_TEXT;
         end else if (pred_count < PARAM_DEPTH) begin
            pred_params[pred_count] = b;
            pred_count++;
         end else begin
            pred_overlong = 1'b1;
         end
      end else if (pred_mode == tesf_pkg::MODE_ESC && b == tesf_pkg::LBRACKET_BYTE) begin
         drop_sequence();
         pred_mode = tesf_pkg::MODE_CSI;
      end else begin
         // release a held ESC, then treat this byte as fresh text
         if (pred_mode == tesf_pkg::MODE_ESC) put_out(tesf_pkg::ESC_BYTE);
         if (b == tesf_pkg::ESC_BYTE) begin
            pred_mode = tesf_pkg::MODE_ESC;
         end else begin
            pred_mode = tesf_pkg::MODE_TEXT;
            put_out(b);
         end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // Hand one request to the filter; return at the edge that takes it.
   task automatic send_req(input logic [7:0] b);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_count++;
   endtask

   task automatic feed_byte(input logic [7:0] b);
      send_req(b);
      filter_byte(b);
      foreach (step_out[i]) expected_out.push_back(step_out[i]);
   endtask

   // Hold off until every owed byte has come out and the filter is idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: after each response byte, stall for a random number of cycles, or not at all during a burst.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         stall_left = rsp_burst ? 0 : $urandom_range(0, 11);
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response byte with the oldest owed byte.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_out.size() == 0) begin
            err_count++;
            $display("%0t: unexpected response: expected none, actual byte %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            head_item = expected_out.pop_front();
            if (rsp_tdata !== head_item.out_byte) begin
               err_count++;
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, head_item.out_byte, rsp_tdata);
            end
            if (rsp_tlast !== head_item.last) begin
               err_count++;
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, head_item.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d response bytes still owed",
                  $time, expected_out.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int         pick;
      int         n;
      int         r;
      int         phase_start;
      logic [6:0] safe_value;

      pred_mode = tesf_pkg::MODE_TEXT;
      pred_safe = tesf_pkg::SAFE_RESET;
      drop_sequence();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: typed rows carry their own expectation, silent rows expect none, the rest is predicted.
      foreach (dir_rows[k]) begin
         send_req(dir_rows[k].data);
         filter_byte(dir_rows[k].data);
         case (dir_rows[k].kind)
            ROW_PREDICTED: begin
               foreach (step_out[i]) expected_out.push_back(step_out[i]);
            end
            ROW_SINGLE: begin
               expected_out.push_back('{out_byte: dir_rows[k].typed, last: 1'b1});
            end
            default: begin
            end
         endcase
      end
      settle();

      // Random part: one safe-byte setting per phase, written only while idle.
      foreach (safe_settings[p]) begin
         safe_value = (p == 4) ?
                      7'($urandom_range(tesf_pkg::FINAL_LO, tesf_pkg::FINAL_HI)) :
                      safe_settings[p];
         csr_tvalid <= 1'b1;
         csr_tdata  <= {1'b0, safe_value};
         @(posedge clock);
         while (!csr_tready) @(posedge clock);
         csr_tvalid <= 1'b0;
         pred_safe = safe_value;

         phase_start = req_count;
         while (req_count - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
            pick = $urandom_range(0, 99);
            if (pick < 60 || pick >= 90) begin
               // control sequence: mostly short, now and then around or past the buffer size
               feed_byte(tesf_pkg::ESC_BYTE);
               feed_byte(tesf_pkg::LBRACKET_BYTE);
               n = ($urandom_range(0, 9) == 0) ?
                   $urandom_range(PARAM_DEPTH - 2, PARAM_DEPTH + 4) : $urandom_range(0, 4);
               if (n > max_params) max_params = n;
               repeat (n) begin
                  // parameter bytes: 0x01..0x3F or 0x7F..0xFF
                  r = $urandom_range(1, 192);
                  feed_byte((r <= 63) ? 8'(r) : 8'(r + 63));
               end
               if (pick >= 90)
                  feed_byte(LINE_END);
               else if (pred_safe >= tesf_pkg::FINAL_LO[6:0] &&
                        pred_safe <= tesf_pkg::FINAL_HI[6:0] &&
                        $urandom_range(0, 2) != 0)
                  feed_byte({1'b0, pred_safe});
               else
                  feed_byte(8'($urandom_range(tesf_pkg::FINAL_LO, tesf_pkg::FINAL_HI)));
            end else if (pick < 75) begin
               feed_byte(tesf_pkg::ESC_BYTE);
               feed_byte(8'($urandom_range(0, 255)));
            end else begin
               feed_byte(8'($urandom_range(0, 255)));
            end
         end
         settle();
      end

      $display("Covered %0d requests and %0d response bytes over %0d safe-byte settings;",
               req_count, rsp_count, 1 + $size(safe_settings));
      $display("longest control sequence had %0d parameter bytes against a buffer of %0d.",
               max_params, PARAM_DEPTH);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
